/* rtl/sab_pkg.sv */
// Shared types and constants for the stack arithmetic unit.
// No dependencies; imported by every module of the block.
package sab_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;

    typedef enum logic [2:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_DIV  = 3'd3,
        CMD_MUL  = 3'd4,
        CMD_MOD  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CM_HOLD  = 2'd0,
        CM_ABOVE = 2'd1,
        CM_BELOW = 2'd2
    } t_cell_mode;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EVAL   = 2'd1,
        S_DIV    = 2'd2,
        S_COMMIT = 2'd3
    } t_state;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic [6:0]               entry_count;
    } t_out_item;

endpackage

/* rtl/sab_cell.sv */
// One stack entry: holds a word and takes it from the neighbor above or below.
// Depends on sab_pkg.
module sab_cell (
    input  logic                        i_clk,
    input  sab_pkg::t_cell_mode         i_mode,
    input  logic [sab_pkg::DATA_W-1:0]  i_above,
    input  logic [sab_pkg::DATA_W-1:0]  i_below,
    output logic [sab_pkg::DATA_W-1:0]  o_value
);
    import sab_pkg::*;

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    always_comb begin
        case (i_mode)
            CM_ABOVE: n_value = i_above;
            CM_BELOW: n_value = i_below;
            default:  n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

/* rtl/sab_divider.sv */
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on sab_pkg.
module sab_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sab_pkg::DATA_W-1:0]  i_dividend,
    input  logic [sab_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [sab_pkg::DATA_W-1:0]  o_quotient,
    output logic [sab_pkg::DATA_W-1:0]  o_remainder
);
    import sab_pkg::*;

    localparam int SW = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [SW-1:0]     r_step;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_div;
    logic              r_neg_q;
    logic              r_neg_r;
    logic [DATA_W+1:0] w_trial;

    assign w_trial = {1'b0, r_rem, r_quo[DATA_W-1]} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SW'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_quo   <= i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_div   <= i_divisor[DATA_W-1] ? (~i_divisor + 1'b1) : i_divisor;
            r_neg_q <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            r_neg_r <= i_dividend[DATA_W-1];
        end else if (r_busy) begin
            if (!w_trial[DATA_W+1]) begin
                r_rem <= w_trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DATA_W-2:0], r_quo[DATA_W-1]};
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_neg_q ? (~r_quo + 1'b1) : r_quo;
    assign o_remainder = r_neg_r ? (~r_rem + 1'b1) : r_rem;

endmodule

/* rtl/stack_alu_binary_ops.sv */
// Stack arithmetic unit: one item at a time, one result item per input item.
// Push, add, sub, mul, unused codes and errors go from idle through evaluate to commit;
// div and mod also wait in the divide state for the bit-serial divider (one bit a cycle).
// The result is registered at commit once the output is free; the next item is accepted in idle.
// A result may wait at the output while the next item is accepted.
// Reset (synchronous, active low) empties the stack; entries need no clearing.
module stack_alu_binary_ops #(
    parameter int STACK_DEPTH = sab_pkg::STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sab_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sab_pkg::t_out_item o_out_data
);
    import sab_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state            r_state;
    t_state            n_state;
    logic [2:0]        r_cmd;
    logic [DATA_W-1:0] r_val;
    logic [1:0]        r_status;
    logic [1:0]        n_status;
    logic [DATA_W-1:0] r_res;
    logic [DATA_W-1:0] n_res;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    t_out_item         r_out_data;
    t_out_item         n_out_data;

    logic              w_accept;
    logic              w_out_free;
    logic              w_fire;
    logic              w_div_start;
    logic              w_div_done;
    logic [DATA_W-1:0] w_quo;
    logic [DATA_W-1:0] w_rem;
    logic              w_is_arith;
    logic              w_do_push;
    logic              w_do_op;
    logic [DATA_W-1:0] w_load;
    t_cell_mode        w_mode_head;
    t_cell_mode        w_mode_body;
    logic [DATA_W-1:0] w_cell [STACK_DEPTH];
    logic [DATA_W-1:0] w_top;
    logic [DATA_W-1:0] w_second;

    assign w_top      = w_cell[0];
    assign w_second   = w_cell[1];
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_is_arith = (r_cmd >= CMD_ADD) && (r_cmd <= CMD_MOD);

    sab_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_second),
        .i_divisor   (w_top),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_res       = r_res;
        w_div_start = 1'b0;
        w_fire      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state  = S_COMMIT;
                n_status = ST_OK;
                case (r_cmd) inside
                    CMD_PUSH: begin
                        if (r_count == CW'(STACK_DEPTH)) begin
                            n_status = ST_FULL;
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
                        if (r_count < CW'(2)) begin
                            n_status = ST_SHORT;
                        end else if ((r_cmd == CMD_DIV || r_cmd == CMD_MOD) &&
                                     w_top == '0) begin
                            n_status = ST_DIVZERO;
                        end else if (r_cmd == CMD_DIV || r_cmd == CMD_MOD) begin
                            w_div_start = 1'b1;
                            n_state     = S_DIV;
                        end else if (r_cmd == CMD_ADD) begin
                            n_res = w_second + w_top;
                        end else if (r_cmd == CMD_SUB) begin
                            n_res = w_second - w_top;
                        end else begin
                            n_res = w_second * w_top;
                        end
                    end
                    default: n_status = ST_OK;
                endcase
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_res   = (r_cmd == CMD_DIV) ? w_quo : w_rem;
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_out_free) begin
                    w_fire  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_do_push = w_fire && (r_status == ST_OK) && (r_cmd == CMD_PUSH);
    assign w_do_op   = w_fire && (r_status == ST_OK) && w_is_arith;
    assign w_load    = w_do_push ? r_val : r_res;

    always_comb begin
        w_mode_head = CM_HOLD;
        w_mode_body = CM_HOLD;
        if (w_do_push) begin
            w_mode_head = CM_ABOVE;
            w_mode_body = CM_ABOVE;
        end else if (w_do_op) begin
            w_mode_head = CM_ABOVE;
            w_mode_body = CM_BELOW;
        end
    end

    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        logic [DATA_W-1:0] w_above;
        logic [DATA_W-1:0] w_below;
        t_cell_mode        w_mode;
        if (gi == 0) begin : g_head
            assign w_above = w_load;
            assign w_mode  = w_mode_head;
        end else begin : g_body
            assign w_above = w_cell[gi-1];
            assign w_mode  = w_mode_body;
        end
        if (gi == STACK_DEPTH - 1) begin : g_tail
            assign w_below = '0;
        end else begin : g_link
            assign w_below = w_cell[gi+1];
        end
        sab_cell u_cell (
            .i_clk   (i_clk),
            .i_mode  (w_mode),
            .i_above (w_above),
            .i_below (w_below),
            .o_value (w_cell[gi])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_do_push) begin
            n_count = r_count + 1'b1;
        end else if (w_do_op) begin
            n_count = r_count - 1'b1;
        end
        n_out_data.status      = r_status;
        n_out_data.entry_count = 7'(n_count);
        if (w_do_push) begin
            n_out_data.top_value = r_val;
        end else if (w_do_op) begin
            n_out_data.top_value = r_res;
        end else if (r_count == '0) begin
            n_out_data.top_value = '0;
        end else begin
            n_out_data.top_value = w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_in_data.cmd;
            r_val <= i_in_data.push_value;
        end
        r_status <= n_status;
        r_res    <= n_res;
        if (w_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/sab_checker.sv */
// Port-level checks for the stack arithmetic unit, bound to the top level.
// Depends on sab_pkg and stack_alu_binary_ops.
module sab_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input sab_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input sab_pkg::t_out_item o_out_data
);
    import sab_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result item changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in flight");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.entry_count == 7'd0 |-> o_out_data.top_value == '0)
        else $error("empty stack reports nonzero top");

    a_short_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_SHORT |-> o_out_data.entry_count < 7'd2)
        else $error("short stack reported with two or more entries");

    a_divzero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_DIVZERO |->
        o_out_data.entry_count >= 7'd2)
        else $error("divide by zero reported on a short stack");

endmodule

bind stack_alu_binary_ops sab_checker u_sab_checker (.*);
